/* sv/short_key_hash64_top_defines.svh */
// Assertion macros for the short-key hash block.
`ifndef SHORT_KEY_HASH64_TOP_DEFINES_SVH
`define SHORT_KEY_HASH64_TOP_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside of reset.
`define SHK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside of reset.
`define SHK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/shk_pkg.sv */
// Package: constants, types and helper functions of the short-key hash pipeline.
`timescale 1ns / 1ps
`default_nettype none

package shk_pkg;

    // Hash constants
    localparam logic [63:0] HK0  = 64'hc3a5c85c97cb3127;
    localparam logic [63:0] HK2  = 64'h9ae16a3b2f90404f;
    localparam logic [63:0] HMUL = 64'h9ddfea08eb382d69;

    localparam int ROT_LAST  = 37;
    localparam int ROT_FIRST = 25;
    localparam int MIX_SHIFT = 47;

    // Pipeline stage map: operand register, five multiply levels of two stages, output
    localparam int ST_OPS     = 0;
    localparam int ST_L1      = 1;
    localparam int ST_L2      = 3;
    localparam int ST_L3      = 5;
    localparam int ST_L4      = 7;
    localparam int ST_L5      = 9;
    localparam int ST_OUT     = 11;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    // Key length class
    typedef enum logic [2:0] {
        MODE_EMPTY,
        MODE_TINY,   // 1..3 bytes
        MODE_SMALL,  // 4..7 bytes
        MODE_MID,    // 8..16 bytes
        MODE_LONG    // above 16 bytes: two windows
    } t_mode;

    // First-level operands of one lane: c = x1*y1 + add, d = x2*y2
    typedef struct packed {
        logic [63:0] x1;
        logic [63:0] y1;
        logic [63:0] add;
        logic [63:0] x2;
        logic [63:0] y2;
        logic [63:0] mulv;   // final multiplier
        logic        tiny;   // 1..3 byte path: finishes after level two
    } t_lane_ops;

    function automatic logic [63:0] f_rotr(input logic [63:0] v, input int s);
        return (v >> s) | (v << (64 - s));
    endfunction

    function automatic logic [63:0] f_mix47(input logic [63:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

endpackage

`default_nettype wire

/* sv/shk_key_if.sv */
// Interface: key item channel (valid/ready with key windows and length).
`timescale 1ns / 1ps
`default_nettype none

interface shk_key_if;
    logic        valid;
    logic        ready;
    logic [63:0] head_low;
    logic [63:0] head_high;
    logic [63:0] tail_low;
    logic [63:0] tail_high;
    logic [31:0] key_length;

    modport source (
        output valid, head_low, head_high, tail_low, tail_high, key_length,
        input  ready
    );
    modport sink (
        input  valid, head_low, head_high, tail_low, tail_high, key_length,
        output ready
    );
endinterface

`default_nettype wire

/* sv/shk_hash_if.sv */
// Interface: hash result item channel (valid/ready with 64-bit hash).
`timescale 1ns / 1ps
`default_nettype none

interface shk_hash_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (
        output valid, hash_value,
        input  ready
    );
    modport sink (
        input  valid, hash_value,
        output ready
    );
endinterface

`default_nettype wire

/* sv/shk_mul64.sv */
// Two-stage 64x64 multiply-add, low 64 bits: 32x32 partial products, then sum.
`timescale 1ns / 1ps
`default_nettype none

module shk_mul64 (
    input  logic        i_clk,
    input  logic        i_en_pp,
    input  logic        i_en_sum,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [63:0] i_c,
    output logic [63:0] o_p
);

    logic [31:0] a_lo, a_hi, b_lo, b_hi;
    logic [63:0] n_ll;
    logic [31:0] n_lh, n_hl;
    logic [63:0] r_ll, r_c;
    logic [31:0] r_lh, r_hl;
    logic [31:0] mid_sum;
    logic [63:0] r_p;

    assign a_lo = i_a[31:0];
    assign a_hi = i_a[63:32];
    assign b_lo = i_b[31:0];
    assign b_hi = i_b[63:32];

    // Partial products; the high-by-high term falls off the top
    assign n_ll = a_lo * b_lo;
    assign n_lh = a_lo * b_hi;
    assign n_hl = a_hi * b_lo;

    always_ff @(posedge i_clk) begin
        if (i_en_pp) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hl <= n_hl;
            r_c  <= i_c;
        end
    end

    // Sum stage
    assign mid_sum = r_lh + r_hl;

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_p <= r_ll + {mid_sum, 32'b0} + r_c;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* sv/shk_prep.sv */
// Length classing and first-level operand setup for the head and tail lanes.
`timescale 1ns / 1ps
`default_nettype none

module shk_prep (
    input  logic [63:0]       i_head_low,
    input  logic [63:0]       i_head_high,
    input  logic [63:0]       i_tail_low,
    input  logic [63:0]       i_tail_high,
    input  logic [31:0]       i_key_length,
    output shk_pkg::t_mode    o_mode,
    output shk_pkg::t_lane_ops o_ops_head,
    output shk_pkg::t_lane_ops o_ops_tail
);

    // 8..16 byte window hash operands
    function automatic shk_pkg::t_lane_ops f_window_ops(
        input logic [63:0] first8,
        input logic [63:0] last8,
        input logic [63:0] mul
    );
        shk_pkg::t_lane_ops ops;
        logic [63:0]        a;
        a        = first8 + shk_pkg::HK2;
        ops.x1   = shk_pkg::f_rotr(last8, shk_pkg::ROT_LAST);
        ops.y1   = mul;
        ops.add  = a;
        ops.x2   = shk_pkg::f_rotr(a, shk_pkg::ROT_FIRST) + last8;
        ops.y2   = mul;
        ops.mulv = mul;
        ops.tiny = 1'b0;
        return ops;
    endfunction

    logic [63:0] len_mul;
    logic [63:0] long_mul;
    logic [3:0]  off;
    logic [63:0] last8;
    logic [31:0] small_b;
    logic [63:0] small_c;
    logic [7:0]  tiny_a, tiny_b, tiny_c;
    logic [1:0]  tiny_ci;
    logic [31:0] tiny_y, tiny_z;

    assign len_mul  = shk_pkg::HK2 + {31'b0, i_key_length, 1'b0};
    assign long_mul = shk_pkg::HK2 + 64'd32;

    // Last eight bytes of an 8..16 byte key, taken from the 16-byte head
    assign off   = 4'(i_key_length[4:0] - 5'd8);
    assign last8 = 64'({i_head_high, i_head_low} >> {off, 3'b000});

    // 4..7 byte path
    assign small_b = 32'(i_head_low >> {i_key_length[1:0], 3'b000});
    assign small_c = {29'b0, i_head_low[31:0], 3'b000} + {32'b0, i_key_length};

    // 1..3 byte path: first, middle and last byte
    assign tiny_ci = 2'(i_key_length[1:0] - 2'd1);
    assign tiny_a  = i_head_low[7:0];
    assign tiny_b  = 8'(i_head_low >> {i_key_length[1], 3'b000});
    assign tiny_c  = 8'(i_head_low >> {tiny_ci, 3'b000});
    assign tiny_y  = {16'b0, tiny_b, tiny_a};
    assign tiny_z  = {22'b0, tiny_c, 2'b00} + i_key_length;

    always_comb begin
        o_mode     = shk_pkg::MODE_EMPTY;
        o_ops_head = '0;
        o_ops_tail = f_window_ops(i_tail_low, i_tail_high, long_mul);

        if (i_key_length == 32'd0) begin
            o_mode = shk_pkg::MODE_EMPTY;
        end else if (i_key_length inside {[32'd1:32'd3]}) begin
            o_mode          = shk_pkg::MODE_TINY;
            o_ops_head.x1   = {32'b0, tiny_y};
            o_ops_head.y1   = shk_pkg::HK2;
            o_ops_head.add  = 64'd0;
            o_ops_head.x2   = {32'b0, tiny_z};
            o_ops_head.y2   = shk_pkg::HK0;
            o_ops_head.mulv = 64'd1;
            o_ops_head.tiny = 1'b1;
        end else if (i_key_length inside {[32'd4:32'd7]}) begin
            // c enters as the addend, d as b times one
            o_mode          = shk_pkg::MODE_SMALL;
            o_ops_head.x1   = 64'd0;
            o_ops_head.y1   = 64'd0;
            o_ops_head.add  = small_c;
            o_ops_head.x2   = {32'b0, small_b};
            o_ops_head.y2   = 64'd1;
            o_ops_head.mulv = len_mul;
            o_ops_head.tiny = 1'b0;
        end else if (i_key_length <= 32'd16) begin
            o_mode     = shk_pkg::MODE_MID;
            o_ops_head = f_window_ops(i_head_low, last8, len_mul);
        end else begin
            o_mode     = shk_pkg::MODE_LONG;
            o_ops_head = f_window_ops(i_head_low, i_head_high, long_mul);
        end
    end

endmodule

`default_nettype wire

/* sv/shk_lane.sv */
// One hash lane: operand register and five pipelined multiply levels.
`timescale 1ns / 1ps
`default_nettype none

module shk_lane (
    input  logic               i_clk,
    input  shk_pkg::t_stage_en i_en,
    input  shk_pkg::t_lane_ops i_ops,
    output logic [63:0]        o_hash
);

    shk_pkg::t_lane_ops r_ops;
    logic [63:0] r_mulv [shk_pkg::ST_L1:shk_pkg::ST_L5-1];
    logic        r_tiny [shk_pkg::ST_L1:shk_pkg::ST_L4-1];
    logic [63:0] r_d    [shk_pkg::ST_L2:shk_pkg::ST_L3-1];

    logic [63:0] c1, d1, u2, v3, w4;
    logic [63:0] l2_x, l2_a, l2_b;
    logic [63:0] l3_a, l3_b, l4_a, l4_b;

    // Operand register and sideband that travels with the item
    always_ff @(posedge i_clk) begin
        if (i_en[shk_pkg::ST_OPS]) begin
            r_ops <= i_ops;
        end
        if (i_en[shk_pkg::ST_L1]) begin
            r_mulv[shk_pkg::ST_L1] <= r_ops.mulv;
            r_tiny[shk_pkg::ST_L1] <= r_ops.tiny;
        end
        for (int k = shk_pkg::ST_L1 + 1; k <= shk_pkg::ST_L5 - 1; k++) begin
            if (i_en[k]) begin
                r_mulv[k] <= r_mulv[k-1];
            end
        end
        for (int k = shk_pkg::ST_L1 + 1; k <= shk_pkg::ST_L4 - 1; k++) begin
            if (i_en[k]) begin
                r_tiny[k] <= r_tiny[k-1];
            end
        end
        if (i_en[shk_pkg::ST_L2]) begin
            r_d[shk_pkg::ST_L2] <= d1;
        end
        if (i_en[shk_pkg::ST_L2+1]) begin
            r_d[shk_pkg::ST_L2+1] <= r_d[shk_pkg::ST_L2];
        end
    end

    // Level 1: c and d
    shk_mul64 u_mul_c (
        .i_clk    (i_clk),
        .i_en_pp  (i_en[shk_pkg::ST_L1]),
        .i_en_sum (i_en[shk_pkg::ST_L1+1]),
        .i_a      (r_ops.x1),
        .i_b      (r_ops.y1),
        .i_c      (r_ops.add),
        .o_p      (c1)
    );

    shk_mul64 u_mul_d (
        .i_clk    (i_clk),
        .i_en_pp  (i_en[shk_pkg::ST_L1]),
        .i_en_sum (i_en[shk_pkg::ST_L1+1]),
        .i_a      (r_ops.x2),
        .i_b      (r_ops.y2),
        .i_c      (64'd0),
        .o_p      (d1)
    );

    // Level 2: (c ^ d) * HMUL, or mix(c ^ d) * HK2 on the 1..3 byte path
    assign l2_x = c1 ^ d1;
    assign l2_a = r_tiny[shk_pkg::ST_L2-1] ? shk_pkg::f_mix47(l2_x) : l2_x;
    assign l2_b = r_tiny[shk_pkg::ST_L2-1] ? shk_pkg::HK2 : shk_pkg::HMUL;

    shk_mul64 u_mul_l2 (
        .i_clk    (i_clk),
        .i_en_pp  (i_en[shk_pkg::ST_L2]),
        .i_en_sum (i_en[shk_pkg::ST_L2+1]),
        .i_a      (l2_a),
        .i_b      (l2_b),
        .i_c      (64'd0),
        .o_p      (u2)
    );

    // Level 3: (d ^ mix(u)) * HMUL; the finished 1..3 byte hash passes times one
    assign l3_a = r_tiny[shk_pkg::ST_L3-1] ? u2
                : (r_d[shk_pkg::ST_L3-1] ^ shk_pkg::f_mix47(u2));
    assign l3_b = r_tiny[shk_pkg::ST_L3-1] ? 64'd1 : shk_pkg::HMUL;

    shk_mul64 u_mul_l3 (
        .i_clk    (i_clk),
        .i_en_pp  (i_en[shk_pkg::ST_L3]),
        .i_en_sum (i_en[shk_pkg::ST_L3+1]),
        .i_a      (l3_a),
        .i_b      (l3_b),
        .i_c      (64'd0),
        .o_p      (v3)
    );

    // Level 4: mix(v) * HMUL
    assign l4_a = r_tiny[shk_pkg::ST_L4-1] ? v3 : shk_pkg::f_mix47(v3);
    assign l4_b = r_tiny[shk_pkg::ST_L4-1] ? 64'd1 : shk_pkg::HMUL;

    shk_mul64 u_mul_l4 (
        .i_clk    (i_clk),
        .i_en_pp  (i_en[shk_pkg::ST_L4]),
        .i_en_sum (i_en[shk_pkg::ST_L4+1]),
        .i_a      (l4_a),
        .i_b      (l4_b),
        .i_c      (64'd0),
        .o_p      (w4)
    );

    // Level 5: final length multiplier (one on the 1..3 byte path)
    shk_mul64 u_mul_l5 (
        .i_clk    (i_clk),
        .i_en_pp  (i_en[shk_pkg::ST_L5]),
        .i_en_sum (i_en[shk_pkg::ST_L5+1]),
        .i_a      (w4),
        .i_b      (r_mulv[shk_pkg::ST_L5-1]),
        .i_c      (64'd0),
        .o_p      (o_hash)
    );

endmodule

`default_nettype wire

/* sv/short_key_hash64_top.sv */
// Top level: pipelined short-key 64-bit hash with valid/ready item channels.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+---------------------------------------------
//   i_key    | in  | valid/ready        | head_low, head_high, tail_low, tail_high,
//            |     |                    | key_length
//   o_hash   | out | valid/ready        | hash_value
//
// One item per cycle unless the output stalls. The pipe is an operand stage, five dependent
// 64-bit multiply levels of two stages each (32x32 partial products, then sum),
// and the output register; the multiply chain of the 8..16 byte hash sets its depth.
// Reset clears only the stage valid bits; the data registers are not reset.
// Each stage holds while its successor is full and stalled; empty stages keep
// filling, so i_key.ready drops only when every stage holds an item.
`timescale 1ns / 1ps
`default_nettype none

`include "short_key_hash64_top_defines.svh"

module short_key_hash64_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shk_key_if.sink     i_key,
    shk_hash_if.source  o_hash
);

    shk_pkg::t_stage_en  r_vld;
    shk_pkg::t_stage_en  en;
    shk_pkg::t_mode      mode;
    shk_pkg::t_mode      r_mode [shk_pkg::ST_OPS:shk_pkg::ST_OUT-1];
    shk_pkg::t_lane_ops  ops_head, ops_tail;
    logic [63:0]         hash_head, hash_tail;
    logic [63:0]         n_hash;
    logic [63:0]         r_hash;

    // Stage k may load when it is empty or some stage at or after it can move
    always_comb begin
        for (int k = 0; k < shk_pkg::NUM_STAGES; k++) begin
            en[k] = o_hash.ready
                 || ((~(r_vld | shk_pkg::t_stage_en'((1 << k) - 1))) != '0);
        end
    end

    assign i_key.ready = en[shk_pkg::ST_OPS];

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[shk_pkg::ST_OPS]) begin
                r_vld[shk_pkg::ST_OPS] <= i_key.valid;
            end
            for (int k = 1; k < shk_pkg::NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Length class and lane operands
    shk_prep u_prep (
        .i_head_low   (i_key.head_low),
        .i_head_high  (i_key.head_high),
        .i_tail_low   (i_key.tail_low),
        .i_tail_high  (i_key.tail_high),
        .i_key_length (i_key.key_length),
        .o_mode       (mode),
        .o_ops_head   (ops_head),
        .o_ops_tail   (ops_tail)
    );

    // Mode travels alongside the lanes
    always_ff @(posedge i_clk) begin
        if (en[shk_pkg::ST_OPS]) begin
            r_mode[shk_pkg::ST_OPS] <= mode;
        end
        for (int k = 1; k < shk_pkg::ST_OUT; k++) begin
            if (en[k]) begin
                r_mode[k] <= r_mode[k-1];
            end
        end
    end

    shk_lane u_lane_head (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ops  (ops_head),
        .o_hash (hash_head)
    );

    shk_lane u_lane_tail (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ops  (ops_tail),
        .o_hash (hash_tail)
    );

    // Final select: empty key constant, two-window fold, or head lane
    always_comb begin
        case (r_mode[shk_pkg::ST_OUT-1])
            shk_pkg::MODE_EMPTY: n_hash = shk_pkg::HK2;
            shk_pkg::MODE_LONG:  n_hash = hash_head ^ hash_tail;
            default:             n_hash = hash_head;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[shk_pkg::ST_OUT]) begin
            r_hash <= n_hash;
        end
    end

    assign o_hash.valid      = r_vld[shk_pkg::ST_OUT];
    assign o_hash.hash_value = r_hash;

    // Checks
    `SHK_ASSERT_NEXT(a_accept_loads, i_key.valid && i_key.ready, r_vld[shk_pkg::ST_OPS], "accepted item not in operand stage")
    `SHK_ASSERT_NOW(a_stall_full, !i_key.ready, &r_vld, "input stalled with an empty stage")
    `SHK_ASSERT_NOW(a_ready_path, o_hash.ready, i_key.ready, "output ready did not reach input")
    `SHK_ASSERT_NEXT(a_out_load, r_vld[shk_pkg::ST_OUT-1] && en[shk_pkg::ST_OUT], r_vld[shk_pkg::ST_OUT], "last stage item lost")

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Testbench for short_key_hash64_top: random and directed keys, scoreboard on every hash.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned RANDOM_KEYS  = 430;
    localparam int unsigned CALM_KEYS    = 60;      // final stretch with no idling
    localparam int unsigned HOLD_START   = 120;     // keys sent before the long back-pressure
    localparam int unsigned LONG_HOLD    = 80;      // well past the 12-stage pipe
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef struct {
        bit [63:0] head_low;
        bit [63:0] head_high;
        bit [63:0] tail_low;
        bit [63:0] tail_high;
        bit [31:0] key_length;
    } key_item_t;

    // Hash predictor plus queue of hashes still owed by the block
    class hash_scoreboard;
        bit [63:0]   expected_q[$];
        int unsigned mismatches;
        int unsigned checked;

        static function bit [63:0] rot_right(bit [63:0] v, int s);
            bit [127:0] w;
            w = {v, v} >> s;
            return w[63:0];
        endfunction

        static function bit [63:0] fold47(bit [63:0] v);
            return v ^ (v >> shk_pkg::MIX_SHIFT);
        endfunction

        static function bit [63:0] pair_mix(bit [63:0] u, bit [63:0] v);
            bit [63:0] a;
            bit [63:0] b;
            a = fold47((u ^ v) * shk_pkg::HMUL);
            b = fold47((v ^ a) * shk_pkg::HMUL);
            return b * shk_pkg::HMUL;
        endfunction

        // 8..16 byte hash from the first and last eight bytes
        static function bit [63:0] mid_key_hash(bit [63:0] first8, bit [63:0] last8,
                                                bit [63:0] len64);
            bit [63:0] mul;
            bit [63:0] a;
            bit [63:0] c;
            bit [63:0] d;
            mul = shk_pkg::HK2 + len64 * 64'd2;
            a   = first8 + shk_pkg::HK2;
            c   = rot_right(last8, shk_pkg::ROT_LAST) * mul + a;
            d   = (rot_right(a, shk_pkg::ROT_FIRST) + last8) * mul;
            return pair_mix(c, d) * mul;
        endfunction

        static function bit [63:0] short_key_hash(bit [63:0] lo, bit [63:0] hi,
                                                  int unsigned len);
            bit [63:0]   len64;
            bit [63:0]   last8;
            bit [63:0]   mul;
            bit [63:0]   a;
            bit [63:0]   b;
            bit [63:0]   c;
            bit [63:0]   y;
            bit [63:0]   z;
            int unsigned off;
            len64 = len;
            if (len >= 8) begin
                off = len - 8;
                if (off == 0) last8 = lo;
                else if (off == 8) last8 = hi;
                else last8 = (lo >> (8 * off)) | (hi << (64 - 8 * off));
                return mid_key_hash(lo, last8, len64);
            end
            if (len >= 4) begin
                mul = shk_pkg::HK2 + len64 * 64'd2;
                a   = {32'd0, lo[31:0]};
                b   = (lo >> (8 * (len - 4))) & 64'hffff_ffff;
                return pair_mix(len64 + (a << 3), b) * mul;
            end
            if (len > 0) begin
                // 1..3 bytes: first, middle and last byte all sit in the low word
                a = lo[7:0];
                b = (lo >> (8 * (len >> 1))) & 64'hff;
                c = (lo >> (8 * (len - 1))) & 64'hff;
                y = (a + (b << 8)) & 64'hffff_ffff;
                z = (len64 + (c << 2)) & 64'hffff_ffff;
                return fold47((y * shk_pkg::HK2) ^ (z * shk_pkg::HK0)) * shk_pkg::HK2;
            end
            return shk_pkg::HK2;
        endfunction

        static function bit [63:0] key_hash(key_item_t k);
            if (k.key_length <= 16)
                return short_key_hash(k.head_low, k.head_high, k.key_length);
            // long key: first window folded with last window, length unused
            return mid_key_hash(k.head_low, k.head_high, 64'd16)
                 ^ mid_key_hash(k.tail_low, k.tail_high, 64'd16);
        endfunction

        function void note_key(key_item_t k);
            expected_q = {expected_q, key_hash(k)};
        endfunction

        function void check_hash(logic [63:0] got);
            bit [63:0] want;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("hash #%0d: unexpected item, got %h", checked, got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("hash #%0d: expected %h, got %h", checked, want, got);
            end
        endfunction

        function void check_leftover();
            if (expected_q.size() != 0) begin
                mismatches++;
                $display("%0d hash items never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    shk_key_if  key_ch ();
    shk_hash_if hash_ch ();

    short_key_hash64_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_ch),
        .o_hash  (hash_ch)
    );

    hash_scoreboard book = new();

    int unsigned keys_sent   = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned cycle_count = 0;
    logic        quiet       = 1'b0;   // no idling on either side
    logic        rx_hold     = 1'b0;   // long receiver back-pressure
    logic        tx_push     = 1'b0;   // sender keeps offering during the hold

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("** short_key_hash64_top: FAILED **");
        $finish;
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit [63:0] rand_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return rand64();
    endfunction

    function automatic int unsigned pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    function automatic key_item_t make_key(bit [63:0] hl, bit [63:0] hh, bit [63:0] tl,
                                           bit [63:0] th, bit [31:0] len);
        key_item_t k;
        k.head_low   = hl;
        k.head_high  = hh;
        k.tail_low   = tl;
        k.tail_high  = th;
        k.key_length = len;
        return k;
    endfunction

    function automatic key_item_t random_key();
        int unsigned r;
        bit [31:0]   len;
        r = $urandom_range(0, 99);
        if (r < 55)      len = $urandom_range(0, 16);
        else if (r < 80) len = $urandom_range(17, 300);
        else if (r < 95) len = $urandom;
        else begin
            case ($urandom_range(0, 3))
                0:       len = 32'd16;
                1:       len = 32'd17;
                2:       len = 32'hffff_ffff;
                default: len = 32'd0;
            endcase
        end
        return make_key(rand_word(), rand_word(), rand_word(), rand_word(), len);
    endfunction

    // Offer one key and wait for it to be taken; now and then idle a random burst after it
    task automatic send_key(input key_item_t k);
        key_ch.valid      <= 1'b1;
        key_ch.head_low   <= k.head_low;
        key_ch.head_high  <= k.head_high;
        key_ch.tail_low   <= k.tail_low;
        key_ch.tail_high  <= k.tail_high;
        key_ch.key_length <= k.key_length;
        do @(posedge i_clk); while (key_ch.ready !== 1'b1);
        book.note_key(k);
        keys_sent++;
        if (keys_sent % 32 == 0) tx_idle_pct = pick_pct();
        if (!quiet && !tx_push && $urandom_range(0, 99) < tx_idle_pct) begin
            key_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Receiver: random stall bursts, long hold when asked, check every taken hash
    initial begin : hash_sink
        int unsigned hold_left;
        int unsigned stall_pct;
        int unsigned cyc;
        hold_left = 0;
        stall_pct = 0;
        cyc       = 0;
        hash_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && hash_ch.valid === 1'b1 && hash_ch.ready === 1'b1)
                book.check_hash(hash_ch.hash_value);
            cyc++;
            if (cyc % 64 == 0) stall_pct = pick_pct();
            if (rx_hold) begin
                hash_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                hash_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                hold_left = $urandom_range(0, 7);
                hash_ch.ready <= 1'b0;
            end else begin
                hash_ch.ready <= 1'b1;
            end
        end
    end

    // Long back-pressure: fill the pipe until the input stalls
    initial begin : long_hold_off
        wait (keys_sent >= HOLD_START);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        tx_push <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        rx_hold <= 1'b0;
        tx_push <= 1'b0;
    end

    // Stimulus
    initial begin : key_source
        bit [63:0] ones;
        ones = '1;
        i_rst_n           <= 1'b0;
        key_ch.valid      <= 1'b0;
        key_ch.head_low   <= '0;
        key_ch.head_high  <= '0;
        key_ch.tail_low   <= '0;
        key_ch.tail_high  <= '0;
        key_ch.key_length <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every length class and its edges, empty key, extreme data,
        // junk beyond the length and in unused tails, very long lengths
        send_key(make_key('0, '0, '0, '0, 32'd0));
        send_key(make_key(ones, ones, ones, ones, 32'd0));
        send_key(make_key(ones, ones, ones, ones, 32'd1));
        send_key(make_key(rand64(), rand64(), rand64(), rand64(), 32'd2));
        send_key(make_key(ones, ones, '0, '0, 32'd3));
        send_key(make_key('0, '0, ones, ones, 32'd4));
        send_key(make_key(rand64(), rand64(), rand64(), rand64(), 32'd5));
        send_key(make_key(rand64(), rand64(), rand64(), rand64(), 32'd6));
        send_key(make_key(ones, ones, ones, ones, 32'd7));
        send_key(make_key(ones, ones, ones, ones, 32'd8));
        send_key(make_key(rand64(), rand64(), rand64(), rand64(), 32'd9));
        send_key(make_key(rand64(), rand64(), rand64(), rand64(), 32'd12));
        send_key(make_key(ones, ones, ones, ones, 32'd15));
        send_key(make_key(ones, ones, '0, '0, 32'd16));
        send_key(make_key('0, '0, ones, ones, 32'd16));
        send_key(make_key(rand64(), rand64(), rand64(), rand64(), 32'd17));
        send_key(make_key(ones, ones, ones, ones, 32'd17));
        send_key(make_key('0, '0, '0, '0, 32'd100));
        send_key(make_key(ones, ones, ones, ones, 32'h8000_0000));
        send_key(make_key(rand64(), rand64(), rand64(), rand64(), 32'hffff_ffff));

        // Random keys; the last stretch runs without idling
        for (int unsigned i = 0; i < RANDOM_KEYS; i++) begin
            if (i == RANDOM_KEYS - CALM_KEYS) quiet <= 1'b1;
            send_key(random_key());
        end
        key_ch.valid <= 1'b0;

        while (book.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        book.check_leftover();
        if (book.mismatches == 0) begin
            $display("** short_key_hash64_top: PASSED **");
        end else begin
            $display("** short_key_hash64_top: FAILED **");
        end
        $finish;
    end

endmodule
